[rtl/cst_pkg.sv]
`default_nettype none
package cst_pkg;

	// Defaults and fixed sizes
	localparam int VALUE_MAX_DEF = 64;
	localparam int CNT_W         = 7;
	localparam int MAX_RES       = 4;
	localparam int FQ_DEPTH      = 4;
	localparam int FQ_AW         = 2;
	localparam int RQ_DEPTH      = 8;
	localparam int RQ_AW         = 3;

	// Scan modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_PEND    = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_WORD    = 3'd3;
	localparam logic [2:0] MODE_STRING  = 3'd4;
	localparam logic [2:0] MODE_DIGITS  = 3'd5;
	localparam logic [2:0] MODE_UNIT    = 3'd6;

	// Token kinds
	localparam logic [2:0] K_EOF   = 3'd0;
	localparam logic [2:0] K_SYM   = 3'd1;
	localparam logic [2:0] K_COMB  = 3'd2;
	localparam logic [2:0] K_HASH  = 3'd3;
	localparam logic [2:0] K_IDENT = 3'd4;
	localparam logic [2:0] K_STR   = 3'd5;
	localparam logic [2:0] K_NUM   = 3'd6;
	localparam logic [2:0] K_DIM   = 3'd7;

	// Characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Byte classes worked out in the front
	typedef struct packed {
		logic letter;
		logic num;
		logic space;
	} cls_t;

	// One queued input item
	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		cls_t       cls;
	} item_t;

	// Front queue head towards the core
	typedef struct packed {
		logic  valid;
		item_t item;
	} fq_head_t;

	// One result item
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic       valid;
		logic       last;
	} res_t;

	// Results of one item, pushed to the result queue together
	typedef struct packed {
		logic [2:0]              n;
		res_t [MAX_RES-1:0]      res;
	} rq_push_t;

	// Scan state plus results being built for one item
	typedef struct packed {
		logic [2:0]       mode;
		logic [7:0]       held;
		logic             hv;
		logic [7:0]       look;
		logic [2:0]       kind;
		logic [CNT_W-1:0] cnt;
		logic             quote;
		logic             star;
		rq_push_t         out;
	} lx_t;

	function automatic cls_t classify(logic [7:0] b);
		cls_t c;
		c.letter = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			b == CH_UNDER || b == CH_MINUS;
		c.num    = (b >= 8'h30 && b <= 8'h39);
		c.space  = b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/css_style_tokenizer_unit.sv]
// An item pushed into the front queue is registered there; the core scans it from the
// queue head and writes its results into the result queue, from which they are popped.
// Throughput: one item per cycle, set by the single scan step in the core, while
// the result queue has at least four free entries; each result then needs one pop.
// Reset: arst_n clears both queues and the scan state at once; no clearing pass.
`default_nettype none
module css_style_tokenizer_unit #(
	parameter int VALUE_MAX = cst_pkg::VALUE_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  byte_in,
	input  wire logic        end_of_text,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       token_kind,
	output logic [7:0]       char_out,
	output logic             char_valid,
	output logic             token_last
);

	cst_pkg::fq_head_t fq_head;
	logic              fq_take;
	logic              rq_room;
	cst_pkg::rq_push_t rq_push;
	cst_pkg::res_t     rq_head;

	// Input queue with byte classification
	cst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.byte_in     (byte_in),
		.end_of_text (end_of_text),
		.head        (fq_head),
		.take        (fq_take)
	);

	// Scanner
	cst_core #(
		.VALUE_MAX (VALUE_MAX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (fq_head),
		.take   (fq_take),
		.room   (rq_room),
		.rpush  (rq_push)
	);

	// Result queue
	cst_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.rpush  (rq_push),
		.room   (rq_room),
		.empty  (empty),
		.pop    (pop),
		.head   (rq_head)
	);

	assign token_kind = rq_head.kind;
	assign char_out   = rq_head.ch;
	assign char_valid = rq_head.valid;
	assign token_last = rq_head.last;

endmodule
`default_nettype wire

[rtl/cst_front.sv]
`default_nettype none
module cst_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [7:0]        byte_in,
	input  wire logic              end_of_text,
	output cst_pkg::fq_head_t      head,
	input  wire logic              take
);

	localparam logic [cst_pkg::FQ_AW:0] DepthC = (cst_pkg::FQ_AW+1)'(cst_pkg::FQ_DEPTH);

	cst_pkg::item_t                mem_q [cst_pkg::FQ_DEPTH];
	logic [cst_pkg::FQ_AW-1:0]     wr_q;
	logic [cst_pkg::FQ_AW-1:0]     rd_q;
	logic [cst_pkg::FQ_AW:0]       cnt_q;
	logic                          do_wr;
	logic                          do_rd;
	cst_pkg::item_t                in_item;

	// Classify the byte on the way in
	always_comb begin
		in_item.ch  = byte_in;
		in_item.eot = end_of_text;
		in_item.cls = cst_pkg::classify(byte_in);
	end

	assign full       = (cnt_q == DepthC);
	assign do_wr      = push && !full;
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_q];
	assign do_rd      = take && head.valid;

	// Item storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= in_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/cst_core.sv]
`default_nettype none
module cst_core #(
	parameter int VALUE_MAX = cst_pkg::VALUE_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cst_pkg::fq_head_t head,
	output logic                   take,
	input  wire logic              room,
	output cst_pkg::rq_push_t      rpush
);

	localparam logic [cst_pkg::CNT_W-1:0] CntLim = cst_pkg::CNT_W'(VALUE_MAX - 1);

	function automatic cst_pkg::lx_t put_res(cst_pkg::lx_t s, logic [2:0] k,
		logic [7:0] c, logic v, logic l);
		if (s.out.n < 3'(cst_pkg::MAX_RES)) begin
			s.out.res[s.out.n[1:0]].kind  = k;
			s.out.res[s.out.n[1:0]].ch    = c;
			s.out.res[s.out.n[1:0]].valid = v;
			s.out.res[s.out.n[1:0]].last  = l;
			s.out.n = s.out.n + 3'd1;
		end
		return s;
	endfunction

	function automatic cst_pkg::lx_t open_tok(cst_pkg::lx_t s, logic [2:0] k,
		logic [2:0] m);
		s.kind = k;
		s.mode = m;
		s.cnt  = '0;
		s.hv   = 1'b0;
		s.held = '0;
		return s;
	endfunction

	function automatic cst_pkg::lx_t take_ch(cst_pkg::lx_t s, logic [7:0] b);
		if (s.cnt < CntLim) begin
			if (s.hv) begin
				s = put_res(s, s.kind, s.held, 1'b1, 1'b0);
			end
			s.held = b;
			s.hv   = 1'b1;
			s.cnt  = s.cnt + 1'b1;
		end
		return s;
	endfunction

	function automatic cst_pkg::lx_t close_tok(cst_pkg::lx_t s);
		if (s.hv) begin
			s = put_res(s, s.kind, s.held, 1'b1, 1'b1);
		end else begin
			s = put_res(s, s.kind, cst_pkg::CH_NUL, 1'b0, 1'b1);
		end
		s.hv   = 1'b0;
		s.held = '0;
		s.cnt  = '0;
		s.mode = cst_pkg::MODE_IDLE;
		return s;
	endfunction

	function automatic cst_pkg::lx_t single_tok(cst_pkg::lx_t s, logic [2:0] k,
		logic [7:0] b);
		s = put_res(s, k, b, 1'b1, 1'b1);
		s.mode = cst_pkg::MODE_IDLE;
		return s;
	endfunction

	// Token start from the idle mode
	function automatic cst_pkg::lx_t start_idle(cst_pkg::lx_t s, logic [7:0] b,
		cst_pkg::cls_t c);
		if (c.space) begin
			s = s;
		end else if (b == cst_pkg::CH_SLASH || b == cst_pkg::CH_DOT ||
			b == cst_pkg::CH_MINUS) begin
			s.look = b;
			s.mode = cst_pkg::MODE_PEND;
		end else if (b == cst_pkg::CH_LBRACE || b == cst_pkg::CH_RBRACE ||
			b == cst_pkg::CH_COLON || b == cst_pkg::CH_SEMI ||
			b == cst_pkg::CH_COMMA || b == cst_pkg::CH_LPAREN ||
			b == cst_pkg::CH_RPAREN || b == cst_pkg::CH_LBRACK ||
			b == cst_pkg::CH_RBRACK) begin
			s = single_tok(s, cst_pkg::K_SYM, b);
		end else if (b == cst_pkg::CH_GT || b == cst_pkg::CH_PLUS ||
			b == cst_pkg::CH_TILDE) begin
			s = single_tok(s, cst_pkg::K_COMB, b);
		end else if (b == cst_pkg::CH_HASH) begin
			s = open_tok(s, cst_pkg::K_HASH, cst_pkg::MODE_WORD);
		end else if (b == cst_pkg::CH_STAR) begin
			s = single_tok(s, cst_pkg::K_IDENT, b);
		end else if (b == cst_pkg::CH_DQUOTE || b == cst_pkg::CH_SQUOTE) begin
			s = open_tok(s, cst_pkg::K_STR, cst_pkg::MODE_STRING);
			s.quote = (b == cst_pkg::CH_SQUOTE);
		end else if (c.num) begin
			s = open_tok(s, cst_pkg::K_NUM, cst_pkg::MODE_DIGITS);
			s = take_ch(s, b);
		end else if (c.letter) begin
			s = open_tok(s, cst_pkg::K_IDENT, cst_pkg::MODE_WORD);
			s = take_ch(s, b);
		end else begin
			s = single_tok(s, cst_pkg::K_SYM, b);
		end
		return s;
	endfunction

	// One text byte: pending char, then open token, then idle start
	function automatic cst_pkg::lx_t feed(cst_pkg::lx_t s, logic [7:0] b,
		cst_pkg::cls_t c);
		logic       done;
		logic [7:0] p;
		done = 1'b0;
		p    = s.look;
		if (s.mode == cst_pkg::MODE_PEND) begin
			s.look = '0;
			s.mode = cst_pkg::MODE_IDLE;
			if (p == cst_pkg::CH_SLASH) begin
				if (b == cst_pkg::CH_STAR) begin
					s.mode = cst_pkg::MODE_COMMENT;
					s.star = 1'b0;
					done   = 1'b1;
				end else begin
					s = single_tok(s, cst_pkg::K_SYM, cst_pkg::CH_SLASH);
				end
			end else if (p == cst_pkg::CH_DOT) begin
				if (c.letter) begin
					s    = open_tok(s, cst_pkg::K_IDENT, cst_pkg::MODE_WORD);
					s    = take_ch(s, cst_pkg::CH_DOT);
					s    = take_ch(s, b);
					done = 1'b1;
				end else begin
					s = single_tok(s, cst_pkg::K_SYM, cst_pkg::CH_DOT);
				end
			end else if (c.num) begin
				s    = open_tok(s, cst_pkg::K_NUM, cst_pkg::MODE_DIGITS);
				s    = take_ch(s, cst_pkg::CH_MINUS);
				s    = take_ch(s, b);
				done = 1'b1;
			end else begin
				s = open_tok(s, cst_pkg::K_IDENT, cst_pkg::MODE_WORD);
				s = take_ch(s, cst_pkg::CH_MINUS);
			end
		end
		if (!done) begin
			case (s.mode)
				cst_pkg::MODE_COMMENT: begin
					if (s.star && b == cst_pkg::CH_SLASH) begin
						s.star = 1'b0;
						s.mode = cst_pkg::MODE_IDLE;
					end else begin
						s.star = (b == cst_pkg::CH_STAR);
					end
					done = 1'b1;
				end
				cst_pkg::MODE_WORD: begin
					if (c.letter || c.num) begin
						s    = take_ch(s, b);
						done = 1'b1;
					end else begin
						s = close_tok(s);
					end
				end
				cst_pkg::MODE_STRING: begin
					if (b == (s.quote ? cst_pkg::CH_SQUOTE : cst_pkg::CH_DQUOTE)) begin
						s       = close_tok(s);
						s.quote = 1'b0;
					end else begin
						s = take_ch(s, b);
					end
					done = 1'b1;
				end
				cst_pkg::MODE_DIGITS: begin
					if (c.num || b == cst_pkg::CH_DOT) begin
						s    = take_ch(s, b);
						done = 1'b1;
					end else if (b == cst_pkg::CH_PCT) begin
						s.kind = cst_pkg::K_DIM;
						s      = take_ch(s, b);
						s      = close_tok(s);
						done   = 1'b1;
					end else if (c.letter) begin
						s.kind = cst_pkg::K_DIM;
						s.mode = cst_pkg::MODE_UNIT;
						s      = take_ch(s, b);
						done   = 1'b1;
					end else begin
						s = close_tok(s);
					end
				end
				cst_pkg::MODE_UNIT: begin
					if (c.letter) begin
						s    = take_ch(s, b);
						done = 1'b1;
					end else begin
						s = close_tok(s);
					end
				end
				default: begin
					s = s;
				end
			endcase
		end
		if (!done) begin
			s.mode = cst_pkg::MODE_IDLE;
			s = start_idle(s, b, c);
		end
		return s;
	endfunction

	// End item: flush, emit EOF, return to reset state
	function automatic cst_pkg::lx_t finish(cst_pkg::lx_t s);
		case (s.mode)
			cst_pkg::MODE_PEND: begin
				if (s.look == cst_pkg::CH_MINUS) begin
					s = single_tok(s, cst_pkg::K_IDENT, cst_pkg::CH_MINUS);
				end else begin
					s = single_tok(s, cst_pkg::K_SYM, s.look);
				end
			end
			cst_pkg::MODE_WORD, cst_pkg::MODE_STRING,
			cst_pkg::MODE_DIGITS, cst_pkg::MODE_UNIT: begin
				s = close_tok(s);
			end
			default: begin
				s = s;
			end
		endcase
		s = put_res(s, cst_pkg::K_EOF, cst_pkg::CH_NUL, 1'b0, 1'b1);
		s.mode  = cst_pkg::MODE_IDLE;
		s.held  = '0;
		s.hv    = 1'b0;
		s.look  = '0;
		s.kind  = cst_pkg::K_EOF;
		s.cnt   = '0;
		s.quote = 1'b0;
		s.star  = 1'b0;
		return s;
	endfunction

	logic [2:0]               mode_q;
	logic [7:0]               held_q;
	logic                     hv_q;
	logic [7:0]               look_q;
	logic [2:0]               kind_q;
	logic [cst_pkg::CNT_W-1:0] cnt_q;
	logic                     quote_q;
	logic                     star_q;
	cst_pkg::lx_t             cur;
	cst_pkg::lx_t             nxt;

	assign take = head.valid && room;

	// Scan step for the head item
	always_comb begin
		cur.mode  = mode_q;
		cur.held  = held_q;
		cur.hv    = hv_q;
		cur.look  = look_q;
		cur.kind  = kind_q;
		cur.cnt   = cnt_q;
		cur.quote = quote_q;
		cur.star  = star_q;
		cur.out   = '0;
		if (head.item.eot) begin
			nxt = finish(cur);
		end else begin
			nxt = feed(cur, head.item.ch, head.item.cls);
		end
	end

	always_comb begin
		rpush = nxt.out;
		if (!take) begin
			rpush.n = '0;
		end
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= cst_pkg::MODE_IDLE;
			held_q  <= '0;
			hv_q    <= 1'b0;
			look_q  <= '0;
			kind_q  <= cst_pkg::K_EOF;
			cnt_q   <= '0;
			quote_q <= 1'b0;
			star_q  <= 1'b0;
		end else if (take) begin
			mode_q  <= nxt.mode;
			held_q  <= nxt.held;
			hv_q    <= nxt.hv;
			look_q  <= nxt.look;
			kind_q  <= nxt.kind;
			cnt_q   <= nxt.cnt;
			quote_q <= nxt.quote;
			star_q  <= nxt.star;
		end
	end

endmodule
`default_nettype wire

[rtl/cst_rq.sv]
`default_nettype none
module cst_rq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cst_pkg::rq_push_t rpush,
	output logic                   room,
	output logic                   empty,
	input  wire logic              pop,
	output cst_pkg::res_t          head
);

	localparam logic [cst_pkg::RQ_AW:0] RoomLim =
		(cst_pkg::RQ_AW+1)'(cst_pkg::RQ_DEPTH - cst_pkg::MAX_RES);

	cst_pkg::res_t                 mem_q [cst_pkg::RQ_DEPTH];
	logic [cst_pkg::RQ_AW-1:0]     wr_q;
	logic [cst_pkg::RQ_AW-1:0]     rd_q;
	logic [cst_pkg::RQ_AW:0]       cnt_q;
	logic                          do_rd;

	assign empty = (cnt_q == '0);
	assign room  = (cnt_q <= RoomLim);
	assign head  = mem_q[rd_q];
	assign do_rd = pop && !empty;

	// Up to MAX_RES results written per cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < cst_pkg::MAX_RES; i++) begin
			if (3'(i) < rpush.n) begin
				mem_q[wr_q + cst_pkg::RQ_AW'(i)] <= rpush.res[i];
			end
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + cst_pkg::RQ_AW'(rpush.n);
			if (do_rd) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (cst_pkg::RQ_AW+1)'(rpush.n) -
				(cst_pkg::RQ_AW+1)'(do_rd);
		end
	end

endmodule
`default_nettype wire
